// ===== rtl/core/trie_insert_search_macros.svh =====
// assertion macros used by the checker in tis_checker.sv
`ifndef TRIE_INSERT_SEARCH_MACROS_SVH
`define TRIE_INSERT_SEARCH_MACROS_SVH

// same-cycle implication, off during reset
`define TIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches reset itself
`define TIS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tis_pkg.sv =====
`default_nettype none
package tis_pkg;

  // controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CALC     = 7'b0000010,
    ST_RD_CHILD = 7'b0000100,
    ST_RD_PAR   = 7'b0001000,
    ST_DECIDE   = 7'b0010000,
    ST_RD_END   = 7'b0100000,
    ST_UPDATE   = 7'b1000000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic calc;
    logic rd_child;
    logic rd_par;
    logic decide;
    logic rd_end;
    logic update;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic skip;   // no walk step for this item
    logic fin;    // item ends the word
  } stat_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/trie_insert_search.sv =====
// states: a walking letter passes calc, child read, parent read and decide; a walking word
//   end adds end read and update; a skipped letter has calc only, a skipped word end calc,
//   end read and update; done, found, status in the first idle cycle. No new transaction is
//   taken while busy; the child, parent and end-mark reads (one read port each) are dependent
// reset: synchronous, the store is empty at once; no clearing pass, the allocation count
//   and parent back-pointers tell live entries from stale ones; results cannot be stalled
`default_nettype none
module trie_insert_search #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // command side: transaction taken when start is high and busy is low
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind,
  input  wire logic [4:0] letter,
  input  wire logic       last,
  input  wire logic       empty_word,
  // result side: one-cycle strobe, receiver has no backpressure
  output logic            done,
  output logic            found,
  output logic            status
);

  // controller steps: slot address, child read, parent check, decide, end read, update
  tis_pkg::cmd_t  cmd;
  tis_pkg::stat_t st;

  tis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath holds the node pool memories and the walk state
  tis_datapath #(
    .MAX_NODES (MAX_NODES),
    .ALPHABET  (ALPHABET)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (kind),
    .letter     (letter),
    .last       (last),
    .empty_word (empty_word),
    .st         (st),
    .found      (found),
    .status     (status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tis_ctrl.sv =====
`default_nettype none
module tis_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire tis_pkg::stat_t st,
  output tis_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);

  tis_pkg::state_t state;
  tis_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      tis_pkg::ST_IDLE: begin
        if (start) state_next = tis_pkg::ST_CALC;
      end
      tis_pkg::ST_CALC: begin
        if (!st.skip) state_next = tis_pkg::ST_RD_CHILD;
        else if (st.fin) state_next = tis_pkg::ST_RD_END;
        else state_next = tis_pkg::ST_IDLE;
      end
      tis_pkg::ST_RD_CHILD: state_next = tis_pkg::ST_RD_PAR;
      tis_pkg::ST_RD_PAR:   state_next = tis_pkg::ST_DECIDE;
      tis_pkg::ST_DECIDE: begin
        if (st.fin) state_next = tis_pkg::ST_RD_END;
        else state_next = tis_pkg::ST_IDLE;
      end
      tis_pkg::ST_RD_END: state_next = tis_pkg::ST_UPDATE;
      tis_pkg::ST_UPDATE: state_next = tis_pkg::ST_IDLE;
      default:            state_next = tis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.latch    = (state == tis_pkg::ST_IDLE) && start;
    cmd.calc     = (state == tis_pkg::ST_CALC);
    cmd.rd_child = (state == tis_pkg::ST_RD_CHILD);
    cmd.rd_par   = (state == tis_pkg::ST_RD_PAR);
    cmd.decide   = (state == tis_pkg::ST_DECIDE);
    cmd.rd_end   = (state == tis_pkg::ST_RD_END);
    cmd.update   = (state == tis_pkg::ST_UPDATE);
  end

  assign busy = (state != tis_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tis_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == tis_pkg::ST_UPDATE);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tis_datapath.sv =====
`default_nettype none
module tis_datapath #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tis_pkg::cmd_t cmd,
  input  wire logic          kind,
  input  wire logic [4:0]    letter,
  input  wire logic          last,
  input  wire logic          empty_word,
  output tis_pkg::stat_t     st,
  output logic               found,
  output logic               status
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int FW    = $clog2(MAX_NODES + 1);
  localparam int SLOTS = MAX_NODES * ALPHABET;
  localparam int SW    = $clog2(SLOTS);

  // child pointers, parent back-pointers, end marks
  // pointer contents at power-up are arbitrary bits, never trusted without the parent check
  bit   [NW-1:0] child_mem [SLOTS];
  bit   [SW-1:0] par_mem   [MAX_NODES];
  logic          end_mem   [MAX_NODES];

  logic          kind_q;
  logic [4:0]    letter_q;
  logic          last_q;
  logic          empty_q;

  logic [NW-1:0] cur;
  logic          miss;
  logic          full;
  logic [FW-1:0] free_cnt;
  logic          root_end;

  logic [SW-1:0] slot_q;
  logic [NW-1:0] child_q;
  logic [SW-1:0] par_q;
  logic          in_range_q;
  logic          end_q;

  logic          letter_bad;
  logic          hit;
  logic          room;
  logic          alloc;
  logic          blocked;
  logic          mark;
  logic          mark_set;
  logic [NW-1:0] new_node;

  assign letter_bad = (32'(letter_q) >= 32'(ALPHABET));
  // a slot holds a child only if it points at an allocated node whose parent is this slot
  assign hit        = in_range_q && (par_q == slot_q);
  assign room       = (free_cnt < FW'(MAX_NODES));
  assign alloc      = cmd.decide && !hit && (kind_q == tis_pkg::KIND_INSERT) && room;
  assign new_node   = NW'(free_cnt);
  assign blocked    = miss || full;
  assign mark       = (cur == '0) ? root_end : end_q;
  assign mark_set   = cmd.update && (kind_q == tis_pkg::KIND_INSERT) && !blocked;

  assign st.skip = empty_q || blocked || letter_bad;
  assign st.fin  = empty_q || last_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q   <= kind;
      letter_q <= letter;
      last_q   <= last;
      empty_q  <= empty_word;
    end
    if (cmd.calc) begin
      slot_q <= SW'(cur) * SW'(ALPHABET) + SW'(letter_q);
    end
    if (cmd.rd_par) begin
      in_range_q <= (child_q != '0) && (FW'(child_q) < free_cnt);
    end
    if (cmd.update) begin
      found  <= (kind_q == tis_pkg::KIND_SEARCH) && !blocked && mark;
      status <= (kind_q == tis_pkg::KIND_INSERT) && full;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) child_mem[slot_q] <= new_node;
    if (cmd.rd_child) child_q <= child_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (alloc) par_mem[new_node] <= slot_q;
    if (cmd.rd_par) par_q <= par_mem[child_q];
  end

  always_ff @(posedge clk) begin
    if (alloc) end_mem[new_node] <= 1'b0;
    else if (mark_set) end_mem[cur] <= 1'b1;
    if (cmd.rd_end) end_q <= end_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      miss     <= 1'b0;
      full     <= 1'b0;
      free_cnt <= FW'(1);
      root_end <= 1'b0;
    end else begin
      if (cmd.calc && !empty_q && !blocked && letter_bad) miss <= 1'b1;
      if (cmd.decide) begin
        if (hit) cur <= child_q;
        else if (kind_q == tis_pkg::KIND_SEARCH) miss <= 1'b1;
        else if (!room) full <= 1'b1;
        else begin
          cur      <= new_node;
          free_cnt <= free_cnt + FW'(1);
        end
      end
      if (mark_set && (cur == '0)) root_end <= 1'b1;
      if (cmd.update) begin
        cur  <= '0;
        miss <= 1'b0;
        full <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tis_checker.sv =====
`default_nettype none
`include "trie_insert_search_macros.svh"
module tis_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       found,
  input wire logic       status
);

  // a taken transaction makes the block busy
  `TIS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "busy did not rise after a transaction")
  // a result comes only right after a busy period
  `TIS_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "done outside a busy end")
  // found and full status never together
  `TIS_ASSERT_NOW(a_excl, done, !(found && status), "found and status both set")
  // reset leaves the block idle
  `TIS_ASSERT_RST(a_reset_idle, rst, !busy && !done, "block not idle after reset")

endmodule

bind trie_insert_search tis_checker u_tis_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .found  (found),
  .status (status)
);
`default_nettype wire

// ===== bench/trie_insert_search_checker.sv =====
module trie_insert_search_checker #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       kind,
  input  logic [4:0] letter,
  input  logic       last,
  input  logic       empty_word,
  input  logic       done,
  input  logic       found,
  input  logic       status,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic POOL_OK   = 1'b0;
  localparam logic POOL_FULL = 1'b1;

  typedef struct packed {
    logic hit;
    logic full;
  } word_result_t;

  int unsigned  child_of [MAX_NODES*ALPHABET];
  bit           word_end [MAX_NODES];
  int unsigned  nodes_used;
  int unsigned  cur_node;
  bit           off_trie;
  bit           pool_hit;
  word_result_t results_due [$];
  word_result_t oldest;

  task automatic clear_store();
    foreach (child_of[i]) child_of[i] = 0;
    foreach (word_end[i]) word_end[i] = 1'b0;
    nodes_used = 1;
    cur_node   = 0;
    off_trie   = 1'b0;
    pool_hit   = 1'b0;
    results_due.delete();
  endtask

  // one step down the trie, allocating on insert
  task automatic follow_letter(input logic k, input logic [4:0] l);
    int unsigned slot;
    if (off_trie || pool_hit) return;
    if (int'(l) >= ALPHABET) begin
      off_trie = 1'b1;
      return;
    end
    slot = cur_node * ALPHABET + l;
    if (child_of[slot] == 0) begin
      if (k == tis_pkg::KIND_SEARCH) begin
        off_trie = 1'b1;
        return;
      end
      if (nodes_used >= MAX_NODES) begin
        pool_hit = 1'b1;
        return;
      end
      child_of[slot] = nodes_used;
      nodes_used++;
    end
    cur_node = child_of[slot];
  endtask

  task automatic advance_trie(input logic k, input logic [4:0] l, input logic lst,
                              input logic emp);
    word_result_t r;
    if (!emp) follow_letter(k, l);
    if (emp || lst) begin
      r.hit  = 1'b0;
      r.full = POOL_OK;
      if (k == tis_pkg::KIND_SEARCH) begin
        r.hit = !(off_trie || pool_hit) && word_end[cur_node];
      end else begin
        if (!(off_trie || pool_hit)) word_end[cur_node] = 1'b1;
        r.full = pool_hit ? POOL_FULL : POOL_OK;
      end
      results_due.insert(results_due.size(), r);
      cur_node = 0;
      off_trie = 1'b0;
      pool_hit = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_store();
    end else begin
      if (done) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result found=%0b status=%0b", $time, found, status);
          errors++;
        end else begin
          oldest = results_due.pop_front();
          if (found !== oldest.hit) begin
            $display("%0t: found mismatch, expected %0b actual %0b", $time, oldest.hit, found);
            errors++;
          end
          if (status !== oldest.full) begin
            $display("%0t: status mismatch, expected %0b actual %0b", $time, oldest.full,
                     status);
            errors++;
          end
        end
      end
      if (start && !busy) advance_trie(kind, letter, last, empty_word);
    end
    pending <= results_due.size();
  end

endmodule

// ===== bench/trie_insert_search_tb.sv =====
module trie_insert_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // a word as the stimulus sees it: up to 32 letters, only the first len are sent
  typedef struct packed {
    logic [5:0]      len;
    logic [31:0][4:0] ltr;
  } word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic       kind;
  logic [4:0] letter;
  logic       last;
  logic       empty_word;
  logic       done;
  logic       found;
  logic       status;

  int    errors;
  int    pending;
  int    full_reports;
  int    items_sent;
  int    idle_pct;
  word_t vocab [$];

  // 12 ns period
  always #6 clk = ~clk;

  trie_insert_search uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .letter     (letter),
    .last       (last),
    .empty_word (empty_word),
    .done       (done),
    .found      (found),
    .status     (status)
  );

  trie_insert_search_checker trie_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .letter     (letter),
    .last       (last),
    .empty_word (empty_word),
    .done       (done),
    .found      (found),
    .status     (status),
    .errors     (errors),
    .pending    (pending)
  );

  // count pool-full reports so the last phase knows when the pool has been exhausted
  always @(posedge clk) begin
    if (!rst && done && status) full_reports++;
  end

  // one transaction: random idle cycles first, then hold start until busy is low at an edge
  task automatic send_item(input logic k, input logic [4:0] l, input logic lst,
                           input logic emp);
    while ($urandom_range(99) < idle_pct) begin
      // idle cycle, fields carry junk that must be ignored
      start      <= 1'b0;
      kind       <= 1'($urandom);
      letter     <= 5'($urandom);
      last       <= 1'($urandom);
      empty_word <= 1'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    letter     <= l;
    last       <= lst;
    empty_word <= emp;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // send a word letter by letter, last marked on the final one; zero length goes as an
  // empty word; mixed gives every letter a random kind
  task automatic send_word(input word_t w, input logic k, input bit mixed);
    logic kk;
    if (w.len == 0) begin
      send_item(k, 5'($urandom), 1'($urandom), 1'b1);
    end else begin
      for (int i = 0; i < w.len; i++) begin
        kk = mixed ? 1'($urandom) : k;
        send_item(kk, w.ltr[i], (i == w.len - 1), 1'b0);
      end
    end
  endtask

  function automatic word_t make_word(int max_letter, int min_len, int max_len);
    word_t w;
    w = '0;
    w.len = 6'($urandom_range(max_len, min_len));
    for (int i = 0; i < 32; i++) w.ltr[i] = 5'($urandom_range(max_letter, 0));
    return w;
  endfunction

  // keep a bounded list of inserted words so searches can hit
  task automatic remember(input word_t w);
    if (vocab.size() < 256) vocab.insert(vocab.size(), w);
    else vocab[$urandom_range(255)] = w;
  endtask

  // stop sending and wait for every outstanding result, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // long fresh inserts until the pool has reported full min_full times or 1200 items are sent
  task automatic fill_pool(input int min_full);
    int    first;
    word_t w;
    first = items_sent;
    while (full_reports < min_full && items_sent - first < 1200) begin
      w = make_word(25, 16, 20);
      send_word(w, tis_pkg::KIND_INSERT, 1'b0);
    end
  endtask

  // mostly well-formed words: short words over a-d so searches revisit shared prefixes,
  // long words over the whole alphabet that eat the node pool, searches of stored words
  // (sometimes one letter short or long), short random searches, empty words, and a share of broken words
  task automatic random_traffic(input int quota, input int min_full);
    int    first;
    int    pick;
    logic  k;
    word_t w;
    first = items_sent;
    while (items_sent - first < quota ||
           (full_reports < min_full && items_sent - first < 4 * quota)) begin
      pick = int'($urandom_range(99));
      k    = 1'($urandom);
      if (pick < 25) begin
        w = make_word(3, 1, 4);
        send_word(w, tis_pkg::KIND_INSERT, 1'b0);
        remember(w);
      end else if (pick < 60) begin
        w = make_word(25, 5, 20);
        send_word(w, tis_pkg::KIND_INSERT, 1'b0);
        remember(w);
      end else if (pick < 85) begin
        if (vocab.size() == 0) w = make_word(3, 1, 4);
        else w = vocab[$urandom_range(vocab.size() - 1)];
        // prefix or extension of a stored word must miss unless stored itself
        if (w.len > 1 && $urandom_range(9) == 0) w.len = w.len - 1;
        else if (w.len < 31 && $urandom_range(9) == 0) w.len = w.len + 1;
        send_word(w, tis_pkg::KIND_SEARCH, 1'b0);
      end else if (pick < 91) begin
        w = make_word(3, 1, 4);
        send_word(w, tis_pkg::KIND_SEARCH, 1'b0);
      end else if (pick < 94) begin
        w = '0;
        send_word(w, k, 1'b0);
      end else begin
        w = make_word(25, 1, 8);
        case ($urandom_range(2))
          0: begin
            // a letter past z somewhere in the word
            w.ltr[$urandom_range(w.len - 1)] = 5'($urandom_range(31, 26));
            send_word(w, k, 1'b0);
          end
          1: send_word(w, k, 1'b1);
          default: begin
            // word cut short by an empty-word item
            for (int i = 0; i < w.len; i++) send_item(k, w.ltr[i], 1'b0, 1'b0);
            send_item(k, 5'($urandom), 1'($urandom), 1'b1);
          end
        endcase
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    kind       <= tis_pkg::KIND_INSERT;
    letter     <= '0;
    last       <= 1'b0;
    empty_word <= 1'b0;
    idle_pct   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty word before and after it is stored, letter field ignored
    send_item(tis_pkg::KIND_SEARCH, 5'd31, 1'b0, 1'b1);
    send_item(tis_pkg::KIND_INSERT, 5'd0, 1'b1, 1'b1);
    send_item(tis_pkg::KIND_SEARCH, 5'd21, 1'b0, 1'b1);
    // highest letter
    send_item(tis_pkg::KIND_INSERT, 5'd25, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd25, 1'b1, 1'b0);
    // out-of-range letter drops the insert, the node for a stays unmarked
    send_item(tis_pkg::KIND_INSERT, 5'd0, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_INSERT, 5'd31, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd0, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd26, 1'b1, 1'b0);
    // mixed kinds: the final item decides the kind of result
    send_item(tis_pkg::KIND_INSERT, 5'd1, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd2, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd1, 1'b1, 1'b0);
    // empty word in the middle ends the word at the node reached
    send_item(tis_pkg::KIND_INSERT, 5'd3, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_INSERT, 5'd7, 1'b0, 1'b1);
    send_item(tis_pkg::KIND_SEARCH, 5'd3, 1'b1, 1'b0);
    // prefix of a stored word does not match
    send_item(tis_pkg::KIND_INSERT, 5'd0, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_INSERT, 5'd1, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_INSERT, 5'd2, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd0, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd1, 1'b1, 1'b0);
    // stopped word: letters after a miss are ignored
    send_item(tis_pkg::KIND_SEARCH, 5'd0, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd30, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd1, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd2, 1'b1, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd0, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd1, 1'b0, 1'b0);
    send_item(tis_pkg::KIND_SEARCH, 5'd2, 1'b1, 1'b0);
    settle();

    // idle cycles before an item, each drawn with a chance of 31 percent
    idle_pct = 31;
    random_traffic(440, 0);
    settle();

    // idle cycles before an item, each drawn with a chance of 62 percent
    idle_pct = 62;
    random_traffic(440, 0);
    settle();

    // back to back: run the pool out, then mixed traffic on the full store
    idle_pct = 0;
    fill_pool(3);
    random_traffic(60, 0);
    settle();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
